@@ hdl/assert_macros.svh @@
// Assertion macros shared by the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/tssb_pkg.sv @@
// Shared types, codes and the scope typing function of the scope structure builder.
package tssb_pkg;

    // token classes
    localparam logic [3:0] CLS_OTHER  = 4'd0;
    localparam logic [3:0] CLS_SEMI   = 4'd1;
    localparam logic [3:0] CLS_LBRACE = 4'd2;
    localparam logic [3:0] CLS_RBRACE = 4'd3;
    localparam logic [3:0] CLS_LPAREN = 4'd4;
    localparam logic [3:0] CLS_IDENT  = 4'd5;
    localparam logic [3:0] CLS_CLASS  = 4'd6;
    localparam logic [3:0] CLS_COND   = 4'd7;
    localparam logic [3:0] CLS_LOOP   = 4'd8;
    localparam logic [3:0] CLS_TRY    = 4'd9;

    // record kinds
    localparam logic [1:0] REC_CONTENT = 2'd0;
    localparam logic [1:0] REC_OPEN    = 2'd1;
    localparam logic [1:0] REC_SIG     = 2'd2;
    localparam logic [1:0] REC_ERROR   = 2'd3;

    // scope types
    localparam logic [2:0] SCOPE_NAKED = 3'd0;
    localparam logic [2:0] SCOPE_FUNC  = 3'd1;
    localparam logic [2:0] SCOPE_CLASS = 3'd2;
    localparam logic [2:0] SCOPE_COND  = 3'd3;
    localparam logic [2:0] SCOPE_LOOP  = 3'd4;
    localparam logic [2:0] SCOPE_TRY   = 3'd5;

    // error codes
    localparam logic [2:0] ERR_EMPTY_STMT   = 3'd0;
    localparam logic [2:0] ERR_MISSING_SEMI = 3'd1;
    localparam logic [2:0] ERR_STRAY_RBRACE = 3'd2;
    localparam logic [2:0] ERR_EOF_STMT     = 3'd3;
    localparam logic [2:0] ERR_EOF_UNCLOSED = 3'd4;
    localparam logic [2:0] ERR_BUF_FULL     = 3'd5;
    localparam logic [2:0] ERR_STACK_FULL   = 3'd6;
    localparam logic [2:0] ERR_SCOPES_FULL  = 3'd7;

    // controller to datapath commands
    typedef struct packed {
        logic       accept;
        logic       load_err;
        logic [2:0] err_code;
        logic       load_open;
        logic       load_tok;
        logic [1:0] tok_kind;
        logic       last;
        logic       buf_write;
        logic       buf_clear;
        logic       rd_start;
        logic       rd_next;
        logic       push;
        logic       pop;
        logic       pop_load;
        logic       clear_all;
    } tssb_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic [3:0] cls;
        logic       eos;
        logic       count_zero;
        logic       buf_full;
        logic       stack_full;
        logic       scopes_full;
        logic       depth_one;
        logic       depth_two;
        logic       drain_last;
        logic       out_free;
    } tssb_sts_t;

    // scope type from the buffered statement
    function automatic logic [2:0] block_type_of(input logic       empty,
                                                 input logic [3:0] first_cls,
                                                 input logic       ident_paren,
                                                 input logic       paren);
        logic [2:0] t;
        t = SCOPE_NAKED;
        if (empty) begin
            t = SCOPE_NAKED;
        end else if (first_cls == CLS_CLASS || ident_paren) begin
            t = paren ? SCOPE_FUNC : SCOPE_CLASS;
        end else if (first_cls == CLS_COND) begin
            t = SCOPE_COND;
        end else if (first_cls == CLS_LOOP) begin
            t = SCOPE_LOOP;
        end else if (first_cls == CLS_TRY) begin
            t = SCOPE_TRY;
        end
        return t;
    endfunction

endpackage

@@ hdl/token_scope_structure_builder.sv @@
// Top level of the scope structure builder: controller, datapath and checks.
// Records: an error or scope-open record is loaded into the output register from the latched
// transaction; a drained statement token passes through the registered buffer read first.
// Flow: a token is taken only in idle, once the last is through; a boundary drains one buffer
// read a cycle while the output is free; a closing brace refetching its parent adds a pop state.
// Reset: synchronous, active low; control state clears at once, memories are not cleared.
`include "assert_macros.svh"

module token_scope_structure_builder
    import tssb_pkg::*;
#(
    parameter int BUFFER_DEPTH = 32,
    parameter int STACK_DEPTH  = 16,
    parameter int MAX_SCOPES   = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] token_kind
    input  logic [3:0]  s_tuser,   // [3:0] token_class
    input  logic        s_tlast,   // end_of_stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [7:0] out_token_kind, [15:8] scope_index,
                                   // [23:16] parent_index, [26:24] block_type,
                                   // [32:27] signature_length, [35:33] error_code,
                                   // [67:36] position, [71:68] zero
    output logic [1:0]  m_tuser,   // [1:0] record_kind
    output logic        m_tlast    // last
);

    tssb_cmd_t   cmd;
    tssb_sts_t   sts;
    logic [7:0]  out_tok;
    logic [7:0]  out_scope;
    logic [7:0]  out_parent;
    logic [2:0]  out_type;
    logic [5:0]  out_slen;
    logic [2:0]  out_err;
    logic [31:0] out_pos;
    logic        load_any;

    tssb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tssb_dp #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .STACK_DEPTH  (STACK_DEPTH),
        .MAX_SCOPES   (MAX_SCOPES)
    ) u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_token_kind       (s_tdata),
        .s_token_class      (s_tuser),
        .s_end_of_stream    (s_tlast),
        .m_tready           (m_tready),
        .m_tvalid           (m_tvalid),
        .m_record_kind      (m_tuser),
        .m_out_token_kind   (out_tok),
        .m_scope_index      (out_scope),
        .m_parent_index     (out_parent),
        .m_block_type       (out_type),
        .m_signature_length (out_slen),
        .m_error_code       (out_err),
        .m_position         (out_pos),
        .m_last             (m_tlast),
        .cmd                (cmd),
        .sts                (sts)
    );

    // pack the result fields
    assign m_tdata = {4'd0, out_pos, out_err, out_slen, out_type, out_parent, out_scope, out_tok};

    assign load_any = cmd.load_err || cmd.load_open || cmd.load_tok;

    // checks on controller and datapath cooperation
    `ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready, "double take")
    `ASSERT_IMPLIES(a_load_when_free, aclk, aresetn, load_any, sts.out_free, "output overwritten")
    `ASSERT_IMPLIES(a_drain_nonempty, aclk, aresetn, cmd.rd_start, !sts.count_zero, "empty drain")
    `ASSERT_NEXT(a_write_counts, aclk, aresetn, cmd.buf_write, !sts.count_zero, "count stuck")

endmodule

@@ hdl/tssb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module tssb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/tssb_ctrl.sv @@
// Controller state machine of the scope structure builder.
module tssb_ctrl
    import tssb_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  tssb_sts_t sts,
    output tssb_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_EXEC    = 3'd1;
    localparam logic [2:0] ST_DRAIN_C = 3'd2;
    localparam logic [2:0] ST_DRAIN_S = 3'd3;
    localparam logic [2:0] ST_POP     = 3'd4;
    localparam logic [2:0] ST_EOS2    = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    // next state and command decode
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (sts.eos) begin
                    // end of stream: leftover statement, then unclosed scopes
                    if (!sts.count_zero) begin
                        if (sts.out_free) begin
                            cmd.load_err = 1'b1;
                            cmd.err_code = ERR_EOF_STMT;
                            cmd.last     = sts.depth_one;
                            if (sts.depth_one) begin
                                cmd.clear_all = 1'b1;
                                state_next    = ST_IDLE;
                            end else begin
                                state_next = ST_EOS2;
                            end
                        end
                    end else if (!sts.depth_one) begin
                        if (sts.out_free) begin
                            cmd.load_err  = 1'b1;
                            cmd.err_code  = ERR_EOF_UNCLOSED;
                            cmd.last      = 1'b1;
                            cmd.clear_all = 1'b1;
                            state_next    = ST_IDLE;
                        end
                    end else begin
                        cmd.clear_all = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end else begin
                    case (sts.cls)
                        CLS_SEMI: begin
                            if (sts.count_zero) begin
                                if (sts.out_free) begin
                                    cmd.load_err = 1'b1;
                                    cmd.err_code = ERR_EMPTY_STMT;
                                    cmd.last     = 1'b1;
                                    state_next   = ST_IDLE;
                                end
                            end else begin
                                cmd.rd_start = 1'b1;
                                state_next   = ST_DRAIN_C;
                            end
                        end
                        CLS_LBRACE: begin
                            if (sts.out_free) begin
                                if (sts.stack_full || sts.scopes_full) begin
                                    cmd.load_err  = 1'b1;
                                    cmd.err_code  = sts.stack_full ? ERR_STACK_FULL
                                                                   : ERR_SCOPES_FULL;
                                    cmd.last      = 1'b1;
                                    cmd.buf_clear = 1'b1;
                                    state_next    = ST_IDLE;
                                end else begin
                                    cmd.load_open = 1'b1;
                                    cmd.last      = sts.count_zero;
                                    cmd.push      = 1'b1;
                                    if (sts.count_zero) begin
                                        cmd.buf_clear = 1'b1;
                                        state_next    = ST_IDLE;
                                    end else begin
                                        cmd.rd_start = 1'b1;
                                        state_next   = ST_DRAIN_S;
                                    end
                                end
                            end
                        end
                        CLS_RBRACE: begin
                            if (!sts.count_zero || sts.depth_one) begin
                                if (sts.out_free) begin
                                    cmd.load_err = 1'b1;
                                    cmd.err_code = !sts.count_zero ? ERR_MISSING_SEMI
                                                                   : ERR_STRAY_RBRACE;
                                    cmd.last     = 1'b1;
                                    state_next   = ST_IDLE;
                                end
                            end else begin
                                cmd.pop    = 1'b1;
                                state_next = sts.depth_two ? ST_IDLE : ST_POP;
                            end
                        end
                        default: begin
                            if (sts.buf_full) begin
                                if (sts.out_free) begin
                                    cmd.load_err = 1'b1;
                                    cmd.err_code = ERR_BUF_FULL;
                                    cmd.last     = 1'b1;
                                    state_next   = ST_IDLE;
                                end
                            end else begin
                                cmd.buf_write = 1'b1;
                                state_next    = ST_IDLE;
                            end
                        end
                    endcase
                end
            end
            ST_DRAIN_C, ST_DRAIN_S: begin
                // one buffered token per cycle while the output slot is free
                if (sts.out_free) begin
                    cmd.load_tok = 1'b1;
                    cmd.tok_kind = (state_reg == ST_DRAIN_S) ? REC_SIG : REC_CONTENT;
                    cmd.last     = sts.drain_last;
                    if (sts.drain_last) begin
                        cmd.buf_clear = 1'b1;
                        state_next    = ST_IDLE;
                    end else begin
                        cmd.rd_next = 1'b1;
                    end
                end
            end
            ST_POP: begin
                cmd.pop_load = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_EOS2: begin
                if (sts.out_free) begin
                    cmd.load_err  = 1'b1;
                    cmd.err_code  = ERR_EOF_UNCLOSED;
                    cmd.last      = 1'b1;
                    cmd.clear_all = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/tssb_dp.sv @@
// Datapath: statement buffer, scope stack, counters and output register.
module tssb_dp
    import tssb_pkg::*;
#(
    parameter int BUFFER_DEPTH = 32,
    parameter int STACK_DEPTH  = 16,
    parameter int MAX_SCOPES   = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [7:0]  s_token_kind,
    input  logic [3:0]  s_token_class,
    input  logic        s_end_of_stream,
    input  logic        m_tready,
    output logic        m_tvalid,
    output logic [1:0]  m_record_kind,
    output logic [7:0]  m_out_token_kind,
    output logic [7:0]  m_scope_index,
    output logic [7:0]  m_parent_index,
    output logic [2:0]  m_block_type,
    output logic [5:0]  m_signature_length,
    output logic [2:0]  m_error_code,
    output logic [31:0] m_position,
    output logic        m_last,
    input  tssb_cmd_t   cmd,
    output tssb_sts_t   sts
);

    localparam int BUF_AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int CNT_W  = $clog2(BUFFER_DEPTH + 1);
    localparam int STK_AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DEP_W  = $clog2(STACK_DEPTH + 1);
    // at least eight bits so the low byte of the index is always there
    localparam int SCP_W  = ($clog2(MAX_SCOPES + 1) > 8) ? $clog2(MAX_SCOPES + 1) : 8;

    // latched transaction
    logic [7:0]        tok_reg;
    logic [3:0]        cls_reg;
    logic              eos_reg;
    logic [31:0]       epos_reg;

    // scope and statement state
    logic [31:0]       pos_reg,     pos_next;
    logic [DEP_W-1:0]  depth_reg,   depth_next;
    logic [SCP_W-1:0]  next_sc_reg, next_sc_next;
    logic [7:0]        cur_sc_reg,  cur_sc_next;
    logic [CNT_W-1:0]  count_reg,   count_next;
    logic [3:0]        first_reg,   first_next;
    logic              paren_reg,   paren_next;
    logic              ipar_reg,    ipar_next;
    logic              ident_reg,   ident_next;
    logic [BUF_AW-1:0] idx_reg,     idx_next;

    // output register
    logic              ov_reg, ov_next;
    logic [1:0]        okind_reg;
    logic [7:0]        otok_reg;
    logic [7:0]        oscope_reg;
    logic [7:0]        oparent_reg;
    logic [2:0]        otype_reg;
    logic [5:0]        oslen_reg;
    logic [2:0]        oerr_reg;
    logic [31:0]       opos_reg;
    logic              olast_reg;

    logic [7:0]        buf_rdata;
    logic              buf_re;
    logic [BUF_AW-1:0] buf_raddr;
    logic [7:0]        stk_rdata;
    logic              out_free;
    logic              load;

    // statement buffer
    assign buf_re    = cmd.rd_start || cmd.rd_next;
    assign buf_raddr = cmd.rd_start ? '0 : idx_reg + BUF_AW'(1);

    tssb_ram #(.WIDTH(8), .DEPTH(BUFFER_DEPTH)) u_buf (
        .aclk  (aclk),
        .we    (cmd.buf_write),
        .waddr (BUF_AW'(count_reg)),
        .wdata (tok_reg),
        .re    (buf_re),
        .raddr (buf_raddr),
        .rdata (buf_rdata)
    );

    // scope stack; entry zero (root) is never stored
    tssb_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH)) u_stk (
        .aclk  (aclk),
        .we    (cmd.push),
        .waddr (STK_AW'(depth_reg)),
        .wdata (next_sc_reg[7:0]),
        .re    (cmd.pop),
        .raddr (STK_AW'(depth_reg - DEP_W'(2))),
        .rdata (stk_rdata)
    );

    // status toward the controller
    assign out_free = !ov_reg || m_tready;
    always_comb begin
        sts.cls         = cls_reg;
        sts.eos         = eos_reg;
        sts.count_zero  = (count_reg == '0);
        sts.buf_full    = (count_reg >= CNT_W'(BUFFER_DEPTH));
        sts.stack_full  = (depth_reg >= DEP_W'(STACK_DEPTH));
        sts.scopes_full = (next_sc_reg >= SCP_W'(MAX_SCOPES));
        sts.depth_one   = (depth_reg == DEP_W'(1));
        sts.depth_two   = (depth_reg == DEP_W'(2));
        sts.drain_last  = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
        sts.out_free    = out_free;
    end

    // latch an accepted transaction; classes above nine act as other
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            tok_reg  <= s_token_kind;
            cls_reg  <= (s_token_class > CLS_TRY) ? CLS_OTHER : s_token_class;
            eos_reg  <= s_end_of_stream;
            epos_reg <= pos_reg;
        end
    end

    // next-state logic for scope and statement state
    always_comb begin
        pos_next     = pos_reg;
        depth_next   = depth_reg;
        next_sc_next = next_sc_reg;
        cur_sc_next  = cur_sc_reg;
        count_next   = count_reg;
        first_next   = first_reg;
        paren_next   = paren_reg;
        ipar_next    = ipar_reg;
        ident_next   = ident_reg;
        idx_next     = idx_reg;

        if (cmd.accept && !s_end_of_stream && (pos_reg != '1)) begin
            pos_next = pos_reg + 32'd1;
        end
        if (cmd.buf_write) begin
            count_next = count_reg + CNT_W'(1);
            if (count_reg == '0) begin
                first_next = cls_reg;
            end
            if (cls_reg == CLS_LPAREN) begin
                paren_next = 1'b1;
                if (ident_reg) begin
                    ipar_next = 1'b1;
                end
            end
            ident_next = (cls_reg == CLS_IDENT);
        end
        if (cmd.rd_start) begin
            idx_next = '0;
        end else if (cmd.rd_next) begin
            idx_next = idx_reg + BUF_AW'(1);
        end
        if (cmd.push) begin
            depth_next   = depth_reg + DEP_W'(1);
            next_sc_next = next_sc_reg + SCP_W'(1);
            cur_sc_next  = next_sc_reg[7:0];
        end
        if (cmd.pop) begin
            depth_next = depth_reg - DEP_W'(1);
            if (depth_reg == DEP_W'(2)) begin
                cur_sc_next = 8'd0;
            end
        end
        if (cmd.pop_load) begin
            cur_sc_next = stk_rdata;
        end
        if (cmd.buf_clear || cmd.clear_all) begin
            count_next = '0;
            first_next = CLS_OTHER;
            paren_next = 1'b0;
            ipar_next  = 1'b0;
            ident_next = 1'b0;
        end
        if (cmd.clear_all) begin
            pos_next     = '0;
            depth_next   = DEP_W'(1);
            next_sc_next = SCP_W'(1);
            cur_sc_next  = 8'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            depth_reg   <= DEP_W'(1);
            next_sc_reg <= SCP_W'(1);
            cur_sc_reg  <= 8'd0;
            count_reg   <= '0;
            first_reg   <= CLS_OTHER;
            paren_reg   <= 1'b0;
            ipar_reg    <= 1'b0;
            ident_reg   <= 1'b0;
            idx_reg     <= '0;
        end else begin
            pos_reg     <= pos_next;
            depth_reg   <= depth_next;
            next_sc_reg <= next_sc_next;
            cur_sc_reg  <= cur_sc_next;
            count_reg   <= count_next;
            first_reg   <= first_next;
            paren_reg   <= paren_next;
            ipar_reg    <= ipar_next;
            ident_reg   <= ident_next;
            idx_reg     <= idx_next;
        end
    end

    // output register valid
    assign load    = cmd.load_err || cmd.load_open || cmd.load_tok;
    assign ov_next = load ? 1'b1 : (m_tready ? 1'b0 : ov_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else begin
            ov_reg <= ov_next;
        end
    end

    // output register payload
    always_ff @(posedge aclk) begin
        if (load) begin
            okind_reg   <= REC_ERROR;
            otok_reg    <= 8'd0;
            oscope_reg  <= 8'd0;
            oparent_reg <= 8'd0;
            otype_reg   <= SCOPE_NAKED;
            oslen_reg   <= 6'd0;
            oerr_reg    <= ERR_EMPTY_STMT;
            opos_reg    <= 32'd0;
            olast_reg   <= cmd.last;
            if (cmd.load_err) begin
                oerr_reg <= cmd.err_code;
                opos_reg <= epos_reg;
            end else if (cmd.load_open) begin
                okind_reg   <= REC_OPEN;
                oscope_reg  <= next_sc_reg[7:0];
                oparent_reg <= cur_sc_reg;
                otype_reg   <= block_type_of(count_reg == '0, first_reg, ipar_reg, paren_reg);
                oslen_reg   <= 6'(count_reg);
            end else begin
                okind_reg  <= cmd.tok_kind;
                otok_reg   <= buf_rdata;
                oscope_reg <= cur_sc_reg;
            end
        end
    end

    assign m_tvalid           = ov_reg;
    assign m_record_kind      = okind_reg;
    assign m_out_token_kind   = otok_reg;
    assign m_scope_index      = oscope_reg;
    assign m_parent_index     = oparent_reg;
    assign m_block_type       = otype_reg;
    assign m_signature_length = oslen_reg;
    assign m_error_code       = oerr_reg;
    assign m_position         = opos_reg;
    assign m_last             = olast_reg;

endmodule
